[hw/rtl/grid_cost_distance_map_macros.svh]
`ifndef GRID_COST_DISTANCE_MAP_MACROS_SVH
`define GRID_COST_DISTANCE_MAP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GCDM_ASSERT_NOW(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcdm check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GCDM_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcdm check failed");

`endif

[hw/rtl/gcdm_pkg.sv]
`default_nettype none
package gcdm_pkg;

    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_SEARCH = 3'd1;
    localparam logic [2:0] OP_TARGET = 3'd2;
    localparam logic [2:0] OP_STEP   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    localparam logic [4:0] GRID_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RELAX,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        DIR_NONE,
        DIR_LEFT,
        DIR_RIGHT,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    typedef enum logic [1:0] {
        MD_PASS,
        MD_CLEAR,
        MD_RELAX
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic        limit_on;
        logic [15:0] move_limit;
        logic [7:0]  value;
        logic        in_grid;
        logic        left_ok;
        logic        east_ok;
        logic        up_ok;
        logic        down_ok;
        logic        is_start;
    } ctrl_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic [7:0]  value;
        logic        limit_on;
        logic [15:0] move_limit;
    } in_t;

    typedef struct packed {
        logic [15:0] road_value;
        logic [15:0] distance_value;
        logic [3:0]  pos_x_out;
        logic [3:0]  pos_y_out;
        logic        arrived;
    } out_t;

endpackage
`default_nettype wire

[hw/rtl/gcdm_cell.sv]
`default_nettype none
module gcdm_cell import gcdm_pkg::*; #(
    parameter int COST_BITS = 8,
    parameter int DIST_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 shift,
    input  wire logic [COST_BITS-1:0] cost_d,
    input  wire logic [DIST_BITS-1:0] road_d,
    input  wire logic [DIST_BITS-1:0] dist_d,
    output logic      [COST_BITS-1:0] cost_q,
    output logic      [DIST_BITS-1:0] road_q,
    output logic      [DIST_BITS-1:0] dist_q
);

    logic [COST_BITS-1:0] cost_reg;
    logic [DIST_BITS-1:0] road_reg;
    logic [DIST_BITS-1:0] dist_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            cost_reg <= cost_d;
        end
    end

    // Stores start out unreached.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            road_reg <= '1;
            dist_reg <= '1;
        end
        else if (shift)
        begin
            road_reg <= road_d;
            dist_reg <= dist_d;
        end
    end

    assign cost_q = cost_reg;
    assign road_q = road_reg;
    assign dist_q = dist_reg;

endmodule
`default_nettype wire

[hw/rtl/gcdm_proc.sv]
`default_nettype none
module gcdm_proc import gcdm_pkg::*; #(
    parameter int COST_BITS = 8,
    parameter int DIST_BITS = 16
) (
    input  wire ctrl_t                ctrl,
    input  wire logic [DIST_BITS-1:0] s_self,
    input  wire logic [DIST_BITS-1:0] s_left,
    input  wire logic [DIST_BITS-1:0] s_right,
    input  wire logic [DIST_BITS-1:0] s_up,
    input  wire logic [DIST_BITS-1:0] s_down,
    input  wire logic [DIST_BITS-1:0] d_self,
    input  wire logic [DIST_BITS-1:0] d_left,
    input  wire logic [DIST_BITS-1:0] d_right,
    input  wire logic [DIST_BITS-1:0] d_up,
    input  wire logic [DIST_BITS-1:0] d_down,
    input  wire logic [COST_BITS-1:0] c_self,
    input  wire logic [COST_BITS-1:0] c_left,
    input  wire logic [COST_BITS-1:0] c_right,
    input  wire logic [COST_BITS-1:0] c_up,
    input  wire logic [COST_BITS-1:0] c_down,
    output logic      [DIST_BITS-1:0] store_new,
    output logic                      changed,
    output dir_t                      dir,
    output logic      [DIST_BITS-1:0] best
);

    localparam logic [DIST_BITS-1:0] DMAX = '1;

    function automatic logic expands(input logic [DIST_BITS-1:0] v, input logic lim,
                                     input logic [15:0] limit);
        return (v != DMAX) && (!lim || (32'(v) <= 32'(limit)));
    endfunction

    // Relax: least expanding neighbor plus own entry cost.
    always_comb
    begin
        logic                 found;
        logic [DIST_BITS-1:0] m;
        logic [DIST_BITS:0]   sum;
        logic [DIST_BITS-1:0] cand;
        found = 1'b0;
        m     = DMAX;
        if (ctrl.left_ok && expands(s_left, ctrl.limit_on, ctrl.move_limit))
        begin
            found = 1'b1;
            m     = s_left;
        end
        if (ctrl.east_ok && expands(s_right, ctrl.limit_on, ctrl.move_limit) && s_right < m)
        begin
            found = 1'b1;
            m     = s_right;
        end
        if (ctrl.up_ok && expands(s_up, ctrl.limit_on, ctrl.move_limit) && s_up < m)
        begin
            found = 1'b1;
            m     = s_up;
        end
        if (ctrl.down_ok && expands(s_down, ctrl.limit_on, ctrl.move_limit) && s_down < m)
        begin
            found = 1'b1;
            m     = s_down;
        end
        sum  = {1'b0, m} + (DIST_BITS+1)'(c_self);
        cand = sum[DIST_BITS] ? DMAX : sum[DIST_BITS-1:0];
        store_new = s_self;
        changed   = 1'b0;
        case (ctrl.mode)
            MD_CLEAR:
            begin
                store_new = ctrl.is_start ? '0 : DMAX;
            end
            MD_RELAX:
            begin
                if (ctrl.in_grid && found && cand < s_self)
                begin
                    store_new = cand;
                    changed   = 1'b1;
                end
            end
            default:
            begin
                store_new = s_self;
            end
        endcase
    end

    // Greedy step: smallest lower passable neighbor, first on a tie.
    always_comb
    begin
        dir  = DIR_NONE;
        best = d_self;
        if (ctrl.left_ok && d_left < best && 32'(c_left) <= 32'(ctrl.value))
        begin
            dir  = DIR_LEFT;
            best = d_left;
        end
        if (ctrl.east_ok && d_right < best && 32'(c_right) <= 32'(ctrl.value))
        begin
            dir  = DIR_RIGHT;
            best = d_right;
        end
        if (ctrl.up_ok && d_up < best && 32'(c_up) <= 32'(ctrl.value))
        begin
            dir  = DIR_UP;
            best = d_up;
        end
        if (ctrl.down_ok && d_down < best && 32'(c_down) <= 32'(ctrl.value))
        begin
            dir  = DIR_DOWN;
            best = d_down;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/grid_cost_distance_map.sv]
// Grid cost distance map. All three stores (entry cost, road, distance) live in one
// ring of MAX_W*MAX_H cells that rotates by one cell per clock while an operation
// runs; a single update point sees an entry together with its four grid neighbors on
// fixed taps of the ring. Cost writes, greedy steps and reads run as a sweep around
// the ring; codes 5 to 7 take no revolution. A search or target first clears its
// store in a clearing revolution, then runs relaxation revolutions until one of them
// lowers no entry. Input is taken only when the block is idle; a finished result
// waits in an output register.
`default_nettype none
module grid_cost_distance_map import gcdm_pkg::*; #(
    parameter int MAX_W     = 16,
    parameter int MAX_H     = 16,
    parameter int COST_BITS = 8,
    parameter int DIST_BITS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_addr,
    input  wire logic [4:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_t        in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_t            out_data
);

    localparam int CELLS = MAX_W * MAX_H;
    localparam int XB    = $clog2(MAX_W);
    localparam int YB    = $clog2(MAX_H);
    localparam int XW    = $clog2(MAX_W + 1);
    localparam int YW    = $clog2(MAX_H + 1);
    localparam int NB    = $clog2(CELLS);
    localparam int PT    = MAX_W;
    localparam int LT    = MAX_W - 1;
    localparam int RT    = MAX_W + 1;
    localparam int UT    = 0;
    localparam int DT    = (2 * MAX_W) % CELLS;
    localparam logic [DIST_BITS-1:0] DMAX = '1;

    state_t          state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    logic [3:0]      cx_reg, cx_next;
    logic [3:0]      cy_reg, cy_next;
    logic [7:0]      val_reg, val_next;
    logic            lim_reg, lim_next;
    logic [15:0]     limit_reg, limit_next;
    logic [XB-1:0]   sx_reg, sx_next;
    logic [YB-1:0]   sy_reg, sy_next;
    logic [XB-1:0]   pos_x_reg, pos_x_next;
    logic [YB-1:0]   pos_y_reg, pos_y_next;
    logic [NB-1:0]   cnt_reg, cnt_next;
    logic [XB-1:0]   px_reg, px_next;
    logic [YB-1:0]   py_reg, py_next;
    logic            chg_reg, chg_next;
    out_t            res_reg, res_next;
    out_t            out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    logic [4:0]      gw_reg;
    logic [4:0]      gh_reg;

    logic [XW-1:0]   ew;
    logic [YW-1:0]   eh;
    logic            shift;
    logic            rev_end;
    logic            hit_cell;
    logic            hit_pos;
    logic            sel_dist;
    ctrl_t           ctrl;

    logic [COST_BITS-1:0] cost_q [CELLS];
    logic [DIST_BITS-1:0] road_q [CELLS];
    logic [DIST_BITS-1:0] dist_q [CELLS];
    logic [COST_BITS-1:0] cost_pt;
    logic [DIST_BITS-1:0] road_pt;
    logic [DIST_BITS-1:0] dist_pt;

    logic [DIST_BITS-1:0] store_new;
    logic                 changed;
    dir_t                 dir;
    logic [DIST_BITS-1:0] best;

    always_comb
    begin
        if (gw_reg == 5'd0)
            ew = XW'(1);
        else if (32'(gw_reg) > MAX_W)
            ew = XW'(MAX_W);
        else
            ew = XW'(gw_reg);
        if (gh_reg == 5'd0)
            eh = YW'(1);
        else if (32'(gh_reg) > MAX_H)
            eh = YW'(MAX_H);
        else
            eh = YW'(gh_reg);
    end

    assign shift    = (state_reg == ST_CLEAR) || (state_reg == ST_RELAX) ||
                      (state_reg == ST_SWEEP);
    assign rev_end  = (32'(cnt_reg) == CELLS - 1);
    assign hit_cell = (32'(px_reg) == 32'(cx_reg)) && (32'(py_reg) == 32'(cy_reg));
    // The step cell is held in sx/sy so a move is taken only once per revolution.
    assign hit_pos  = (px_reg == sx_reg) && (py_reg == sy_reg);
    assign sel_dist = (op_reg == OP_TARGET);

    always_comb
    begin
        ctrl.mode       = (state_reg == ST_CLEAR) ? MD_CLEAR :
                          (state_reg == ST_RELAX) ? MD_RELAX : MD_PASS;
        ctrl.limit_on   = lim_reg && (op_reg == OP_SEARCH);
        ctrl.move_limit = limit_reg;
        ctrl.value      = val_reg;
        ctrl.in_grid    = (32'(px_reg) < 32'(ew)) && (32'(py_reg) < 32'(eh));
        ctrl.left_ok    = (px_reg != '0);
        ctrl.east_ok    = (32'(px_reg) + 1 < 32'(ew));
        ctrl.up_ok      = (py_reg != '0);
        ctrl.down_ok    = (32'(py_reg) + 1 < 32'(eh));
        ctrl.is_start   = (px_reg == sx_reg) && (py_reg == sy_reg);
    end

    gcdm_proc #(
        .COST_BITS(COST_BITS),
        .DIST_BITS(DIST_BITS)
    ) u_proc (
        .ctrl     (ctrl),
        .s_self   (sel_dist ? dist_q[PT] : road_q[PT]),
        .s_left   (sel_dist ? dist_q[LT] : road_q[LT]),
        .s_right  (sel_dist ? dist_q[RT] : road_q[RT]),
        .s_up     (sel_dist ? dist_q[UT] : road_q[UT]),
        .s_down   (sel_dist ? dist_q[DT] : road_q[DT]),
        .d_self   (dist_q[PT]),
        .d_left   (dist_q[LT]),
        .d_right  (dist_q[RT]),
        .d_up     (dist_q[UT]),
        .d_down   (dist_q[DT]),
        .c_self   (cost_q[PT]),
        .c_left   (cost_q[LT]),
        .c_right  (cost_q[RT]),
        .c_up     (cost_q[UT]),
        .c_down   (cost_q[DT]),
        .store_new(store_new),
        .changed  (changed),
        .dir      (dir),
        .best     (best)
    );

    // Value leaving the update point.
    always_comb
    begin
        cost_pt = cost_q[PT];
        road_pt = road_q[PT];
        dist_pt = dist_q[PT];
        if (state_reg == ST_SWEEP && op_reg == OP_WRITE && hit_cell)
            cost_pt = COST_BITS'(val_reg);
        if (state_reg == ST_CLEAR || state_reg == ST_RELAX)
        begin
            if (sel_dist)
                dist_pt = store_new;
            else
                road_pt = store_new;
        end
    end

    for (genvar k = 0; k < CELLS; k++)
    begin : g_ring
        logic [COST_BITS-1:0] cost_d;
        logic [DIST_BITS-1:0] road_d;
        logic [DIST_BITS-1:0] dist_d;
        if (k == LT)
        begin : g_pt
            assign cost_d = cost_pt;
            assign road_d = road_pt;
            assign dist_d = dist_pt;
        end
        else if (k == CELLS - 1)
        begin : g_wrap
            assign cost_d = cost_q[0];
            assign road_d = road_q[0];
            assign dist_d = dist_q[0];
        end
        else
        begin : g_link
            assign cost_d = cost_q[k+1];
            assign road_d = road_q[k+1];
            assign dist_d = dist_q[k+1];
        end
        gcdm_cell #(
            .COST_BITS(COST_BITS),
            .DIST_BITS(DIST_BITS)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .cost_d(cost_d),
            .road_d(road_d),
            .dist_d(dist_d),
            .cost_q(cost_q[k]),
            .road_q(road_q[k]),
            .dist_q(dist_q[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= GRID_RESET;
            gh_reg <= GRID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_GRID_WIDTH:  gw_reg <= cfg_data;
                CFG_GRID_HEIGHT: gh_reg <= cfg_data;
                default:         gw_reg <= gw_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            cnt_reg       <= '0;
            px_reg        <= '0;
            py_reg        <= YB'(1);
            chg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            cnt_reg       <= cnt_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            chg_reg       <= chg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        val_reg   <= val_next;
        lim_reg   <= lim_next;
        limit_reg <= limit_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        val_next       = val_reg;
        lim_next       = lim_reg;
        limit_next     = limit_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        cnt_next       = cnt_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        chg_next       = chg_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        // Advance the ring position.
        if (shift)
        begin
            cnt_next = rev_end ? '0 : cnt_reg + NB'(1);
            if (32'(px_reg) == MAX_W - 1)
            begin
                px_next = '0;
                py_next = (32'(py_reg) == MAX_H - 1) ? '0 : py_reg + YB'(1);
            end
            else
            begin
                px_next = px_reg + XB'(1);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.op;
                    cx_next    = in_data.cell_x;
                    cy_next    = in_data.cell_y;
                    val_next   = in_data.value;
                    lim_next   = in_data.limit_on;
                    limit_next = in_data.move_limit;
                    sx_next    = (32'(in_data.cell_x) >= 32'(ew)) ? XB'(32'(ew) - 1) :
                                 XB'(in_data.cell_x);
                    sy_next    = (32'(in_data.cell_y) >= 32'(eh)) ? YB'(32'(eh) - 1) :
                                 YB'(in_data.cell_y);
                    res_next   = '0;
                    chg_next   = 1'b0;
                    case (in_data.op)
                        OP_WRITE:
                        begin
                            state_next = ST_SWEEP;
                        end
                        OP_SEARCH:
                        begin
                            pos_x_next = sx_next;
                            pos_y_next = sy_next;
                            state_next = ST_CLEAR;
                        end
                        OP_TARGET:
                        begin
                            state_next = ST_CLEAR;
                        end
                        OP_STEP:
                        begin
                            if (32'(pos_x_reg) >= 32'(ew))
                                pos_x_next = XB'(32'(ew) - 1);
                            if (32'(pos_y_reg) >= 32'(eh))
                                pos_y_next = YB'(32'(eh) - 1);
                            sx_next    = pos_x_next;
                            sy_next    = pos_y_next;
                            state_next = ST_SWEEP;
                        end
                        OP_READ:
                        begin
                            if (32'(in_data.cell_x) >= MAX_W || 32'(in_data.cell_y) >= MAX_H)
                            begin
                                res_next.road_value     = 16'(DMAX);
                                res_next.distance_value = 16'(DMAX);
                            end
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (rev_end)
                begin
                    chg_next   = 1'b0;
                    state_next = ST_RELAX;
                end
            end
            ST_RELAX:
            begin
                if (rev_end)
                begin
                    chg_next   = 1'b0;
                    state_next = (chg_reg || changed) ? ST_RELAX : ST_DONE;
                end
                else if (changed)
                begin
                    chg_next = 1'b1;
                end
            end
            ST_SWEEP:
            begin
                if (op_reg == OP_READ && hit_cell)
                begin
                    res_next.road_value     = 16'(road_q[PT]);
                    res_next.distance_value = 16'(dist_q[PT]);
                end
                if (op_reg == OP_STEP && hit_pos)
                begin
                    res_next.arrived = (best == '0);
                    case (dir)
                        DIR_LEFT:  pos_x_next = pos_x_reg - XB'(1);
                        DIR_RIGHT: pos_x_next = pos_x_reg + XB'(1);
                        DIR_UP:    pos_y_next = pos_y_reg - YB'(1);
                        DIR_DOWN:  pos_y_next = pos_y_reg + YB'(1);
                        default:   pos_x_next = pos_x_reg;
                    endcase
                end
                if (rev_end)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_next           = res_reg;
                    out_next.pos_x_out = 4'(pos_x_reg);
                    out_next.pos_y_out = 4'(pos_y_reg);
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

[hw/rtl/gcdm_checker.sv]
`default_nettype none
`include "grid_cost_distance_map_macros.svh"
module gcdm_checker import gcdm_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire out_t out_data
);

    // A transfer in always starts work.
    `GCDM_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)
    `GCDM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    // A new result shows up only at the end of an operation.
    `GCDM_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall))
    `GCDM_ASSERT_NOW(a_arrived_fields, out_valid && out_data.arrived,
                     out_data.road_value == 16'd0 && out_data.distance_value == 16'd0)

endmodule

bind grid_cost_distance_map gcdm_checker u_checker (.*);
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
    import gcdm_pkg::*;

    localparam int CELLS = 256;
    localparam logic [15:0] UNREACHED = 16'hFFFF;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_addr;
    logic [4:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    in_t        in_data;
    logic       out_valid;
    logic       out_stall;
    out_t       out_data;

    grid_cost_distance_map i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // map model
    logic [7:0]  cost_map [CELLS];
    logic [15:0] road_map [CELLS];
    logic [15:0] dist_map [CELLS];
    logic [3:0]  cur_x;
    logic [3:0]  cur_y;
    logic [4:0]  grid_w_reg;
    logic [4:0]  grid_h_reg;

    out_t pending_results[$];
    int   mismatches;
    bit   idle_on;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int used_w();
        if (grid_w_reg < 1) return 1;
        if (grid_w_reg > 16) return 16;
        return grid_w_reg;
    endfunction

    function automatic int used_h();
        if (grid_h_reg < 1) return 1;
        if (grid_h_reg > 16) return 16;
        return grid_h_reg;
    endfunction

    function automatic int clip(int v, int n);
        return (v >= n) ? n - 1 : v;
    endfunction

    task automatic compute_paths(input bit to_road, input int sx, input int sy,
                                 input bit lim, input int limit);
        int cost_sum [CELLS];
        int w;
        int h;
        int v;
        int n;
        int cand;
        int dx [4];
        int dy [4];
        bit changed;
        w = used_w();
        h = used_h();
        dx = '{-1, 1, 0, 0};
        dy = '{0, 0, -1, 1};
        for (int i = 0; i < CELLS; i++) cost_sum[i] = 65535;
        cost_sum[sy * 16 + sx] = 0;
        changed = 1'b1;
        while (changed)
        begin
            changed = 1'b0;
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                begin
                    v = cost_sum[y * 16 + x];
                    if (v >= 65535 || (lim && v > limit)) continue;
                    for (int d = 0; d < 4; d++)
                    begin
                        if (x + dx[d] < 0 || x + dx[d] >= w) continue;
                        if (y + dy[d] < 0 || y + dy[d] >= h) continue;
                        n = (y + dy[d]) * 16 + x + dx[d];
                        cand = v + cost_map[n];
                        if (cand > 65535) cand = 65535;
                        if (cand < cost_sum[n])
                        begin
                            cost_sum[n] = cand;
                            changed = 1'b1;
                        end
                    end
                end
        end
        for (int i = 0; i < CELLS; i++)
            if (to_road) road_map[i] = cost_sum[i][15:0];
            else dist_map[i] = cost_sum[i][15:0];
    endtask

    task automatic predict_cell_op(input in_t item, output out_t res);
        int w;
        int h;
        int px;
        int py;
        int best;
        int pick_dir;
        int n;
        int dx [4];
        int dy [4];
        w = used_w();
        h = used_h();
        dx = '{-1, 1, 0, 0};
        dy = '{0, 0, -1, 1};
        res = '0;
        case (item.op)
            OP_WRITE: cost_map[item.cell_y * 16 + item.cell_x] = item.value;
            OP_SEARCH:
            begin
                cur_x = 4'(clip(item.cell_x, w));
                cur_y = 4'(clip(item.cell_y, h));
                compute_paths(1'b1, cur_x, cur_y, item.limit_on, item.move_limit);
            end
            OP_TARGET: compute_paths(1'b0, clip(item.cell_x, w), clip(item.cell_y, h), 1'b0, 0);
            OP_STEP:
            begin
                px = clip(cur_x, w);
                py = clip(cur_y, h);
                best = dist_map[py * 16 + px];
                pick_dir = -1;
                // smallest strictly smaller neighbor; on a tie the earlier in left, right, up, down order
                for (int d = 0; d < 4; d++)
                begin
                    if (px + dx[d] < 0 || px + dx[d] >= w) continue;
                    if (py + dy[d] < 0 || py + dy[d] >= h) continue;
                    n = (py + dy[d]) * 16 + px + dx[d];
                    if (dist_map[n] < best && cost_map[n] <= item.value)
                    begin
                        best = dist_map[n];
                        pick_dir = d;
                    end
                end
                if (pick_dir >= 0)
                begin
                    px = px + dx[pick_dir];
                    py = py + dy[pick_dir];
                end
                cur_x = 4'(px);
                cur_y = 4'(py);
                res.arrived = (dist_map[py * 16 + px] == 16'd0);
            end
            OP_READ:
            begin
                res.road_value     = road_map[item.cell_y * 16 + item.cell_x];
                res.distance_value = dist_map[item.cell_y * 16 + item.cell_x];
            end
            default: ;
        endcase
        res.pos_x_out = cur_x;
        res.pos_y_out = cur_y;
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (out_data.road_value !== want.road_value)
                    report("road_value", out_data.road_value, want.road_value);
                if (out_data.distance_value !== want.distance_value)
                    report("distance_value", out_data.distance_value, want.distance_value);
                if (out_data.pos_x_out !== want.pos_x_out)
                    report("pos_x_out", out_data.pos_x_out, want.pos_x_out);
                if (out_data.pos_y_out !== want.pos_y_out)
                    report("pos_y_out", out_data.pos_y_out, want.pos_y_out);
                if (out_data.arrived !== want.arrived)
                    report("arrived", out_data.arrived, want.arrived);
            end
        end
    end

    // result side back-pressure in bursts
    always @(negedge clk)
    begin
        int run_left;
        if (!idle_on)
            out_stall <= 1'b0;
        else if (run_left > 0)
            run_left--;
        else if ($urandom_range(0, 1))
        begin
            out_stall <= 1'b1;
            run_left = $urandom_range(0, 12);
        end
        else
        begin
            out_stall <= 1'b0;
            run_left = $urandom_range(0, 19);
        end
    end

    task automatic send_cell_op(input in_t item);
        out_t res;
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        predict_cell_op(item, res);
        pending_results.push_back(res);
        @(negedge clk);
    endtask

    function automatic in_t make_op(logic [2:0] op, int x, int y, int val,
                                    bit lim, int limit);
        in_t item;
        item.op         = op;
        item.cell_x     = 4'(x);
        item.cell_y     = 4'(y);
        item.value      = 8'(val);
        item.limit_on   = lim;
        item.move_limit = 16'(limit);
        return item;
    endfunction

    function automatic in_t random_op(int weight_step);
        int pick;
        in_t item;
        item = make_op(OP_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 255), $urandom_range(0, 1),
                       $urandom_range(0, 1) ? $urandom_range(0, 600) : $urandom_range(0, 65534));
        pick = $urandom_range(0, 99);
        if (pick < 18) item.op = OP_WRITE;
        else if (pick < 30) item.op = OP_SEARCH;
        else if (pick < 42) item.op = OP_TARGET;
        else if (pick < 42 + weight_step) item.op = OP_STEP;
        else if (pick < 95) item.op = OP_READ;
        else item.op = 3'(5 + $urandom_range(0, 2));
        if (item.op == OP_WRITE && $urandom_range(0, 3) != 0)
            item.value = 8'($urandom_range(0, 20));
        return item;
    endfunction

    // quiet the block, then write both grid registers
    task automatic set_grid(input int w, input int h);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_GRID_WIDTH;
        cfg_data <= 5'(w);
        @(negedge clk);
        cfg_addr <= CFG_GRID_HEIGHT;
        cfg_data <= 5'(h);
        @(negedge clk);
        cfg_we <= 1'b0;
        grid_w_reg = 5'(w);
        grid_h_reg = 5'(h);
    endtask

    task automatic test_reset_state();
        send_cell_op(make_op(OP_READ, 0, 0, 0, 0, 0));
        send_cell_op(make_op(OP_READ, 15, 15, 255, 1, 65534));
    endtask

    // searches stay inside the loaded 8 by 8 corner
    task automatic test_load_costs();
        set_grid(8, 8);
        for (int i = 0; i < 64; i++)
            send_cell_op(make_op(OP_WRITE, i % 8, i / 8, $urandom_range(0, 9), 0, 0));
    endtask

    task automatic test_directed();
        send_cell_op(make_op(OP_WRITE, 7, 7, 255, 0, 0));
        send_cell_op(make_op(OP_WRITE, 0, 0, 0, 0, 0));
        send_cell_op(make_op(OP_SEARCH, 0, 0, 0, 0, 0));
        send_cell_op(make_op(OP_READ, 15, 15, 0, 0, 0));
        send_cell_op(make_op(OP_SEARCH, 7, 7, 0, 1, 0));
        send_cell_op(make_op(OP_READ, 7, 6, 0, 0, 0));
        send_cell_op(make_op(OP_SEARCH, 15, 0, 0, 1, 65534));
        send_cell_op(make_op(OP_TARGET, 15, 15, 0, 0, 0));
        send_cell_op(make_op(OP_STEP, 0, 0, 0, 0, 0));
        repeat (4) send_cell_op(make_op(OP_STEP, 0, 0, 255, 0, 0));
        send_cell_op(make_op(3'd5, 15, 15, 255, 1, 65534));
        send_cell_op(make_op(3'd6, 0, 0, 0, 0, 0));
        send_cell_op(make_op(3'd7, 3, 3, 3, 1, 3));
        // shrink below the current position, then step and search past the edge
        set_grid(4, 3);
        send_cell_op(make_op(OP_STEP, 0, 0, 255, 0, 0));
        send_cell_op(make_op(OP_TARGET, 15, 15, 0, 0, 0));
        send_cell_op(make_op(OP_SEARCH, 15, 15, 0, 1, 5));
        send_cell_op(make_op(OP_READ, 3, 2, 0, 0, 0));
        set_grid(0, 0);
        send_cell_op(make_op(OP_SEARCH, 9, 9, 0, 0, 0));
        send_cell_op(make_op(OP_STEP, 0, 0, 255, 0, 0));
        send_cell_op(make_op(OP_READ, 0, 0, 0, 0, 0));
        set_grid(31, 31);
        send_cell_op(make_op(OP_STEP, 0, 0, 255, 0, 0));
        send_cell_op(make_op(OP_READ, 0, 15, 0, 0, 0));
    endtask

    task automatic test_random_phase(input int w, input int h, input int count);
        set_grid(w, h);
        for (int i = 0; i < count; i++)
            // one time in five, follow a fresh target with a walk toward it
            if ($urandom_range(0, 4) == 0)
            begin
                send_cell_op(make_op(OP_TARGET, $urandom_range(0, 15), $urandom_range(0, 15),
                                     0, 0, 0));
                repeat ($urandom_range(2, 6))
                    send_cell_op(make_op(OP_STEP, 0, 0,
                                         $urandom_range(0, 3) ? 255 : $urandom_range(0, 10),
                                         0, 0));
            end
            else
                send_cell_op(random_op(30));
    endtask

    initial
    begin
        #1s;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = CFG_GRID_WIDTH;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        mismatches = 0;
        idle_on    = 1'b1;
        cur_x      = '0;
        cur_y      = '0;
        grid_w_reg = GRID_RESET;
        grid_h_reg = GRID_RESET;
        for (int i = 0; i < CELLS; i++)
        begin
            cost_map[i] = '0;
            road_map[i] = UNREACHED;
            dist_map[i] = UNREACHED;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_load_costs();
        test_directed();
        test_random_phase(8, 8, 8);
        test_random_phase($urandom_range(1, 8), $urandom_range(1, 8), 6);
        test_random_phase(1, 8, 4);
        test_random_phase($urandom_range(2, 8), $urandom_range(2, 8), 6);
        idle_on = 1'b0;
        test_random_phase(8, $urandom_range(1, 8), 6);

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[grid_cost_distance_map.f]
+incdir+hw/rtl
hw/rtl/gcdm_pkg.sv
hw/rtl/gcdm_cell.sv
hw/rtl/gcdm_proc.sv
hw/rtl/grid_cost_distance_map.sv
hw/rtl/gcdm_checker.sv
dv/tb.sv
